// File: hw/rtl/s2i_pkg.sv
// shared types and constants of the ucs2 string to integer parser
// no dependencies; imported by every module of the block

package s2i_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_RADIX  = 2'd0;
  localparam logic [1:0] REG_SIGNED = 2'd1;
  localparam logic [1:0] REG_WIDE   = 2'd2;

  localparam logic [5:0] RADIX_RESET   = 6'd10;
  localparam logic [5:0] RADIX_DEFAULT = 6'd10;
  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;

  // character codes
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_0     = 16'h0030;
  localparam logic [15:0] CH_9     = 16'h0039;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UZ    = 16'h005A;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LZ    = 16'h007A;
  localparam logic [15:0] LETTER_BASE = 16'd10;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam int unsigned STOP_W = 13;

  typedef enum logic [1:0] {
    CL_SKIP,
    CL_MINUS,
    CL_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_DIGITS,
    PH_STOPPED
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_RANGE
  } status_e;

  // one classified code unit
  typedef struct packed {
    cls_e       cls;
    logic       dig_ok;
    logic [5:0] dval;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [5:0] radix;
    logic       signed_mode;
    logic       wide_mode;
  } cfg_t;

  // end-of-string snapshot handed to the result stage
  typedef struct packed {
    logic [63:0]       acc;
    logic              minus;
    logic              ovf;
    logic              seen;
    logic              signed_mode;
    logic              wide_mode;
    logic [STOP_W-1:0] stop;
  } fin_t;

endpackage

// File: hw/rtl/ucs2_string_to_integer_core.sv
// top level of the ucs2 string to integer parser: configuration registers,
// front classifier, item queue and back end; depends on s2i_pkg and s2i_* modules

// Parses a stream of 16-bit UCS-2 code units, one string per run ending in
// tlast, into an integer. Leading spaces, tabs and plus signs are skipped and
// every minus sign flips the sign; digits 0-9, a-z, A-Z below the radix are
// accumulated, and the first other unit stops the number. Each string gives one
// result transfer with value, status (ok, no digits, out of range) and the stop
// position (index of the terminating unit, or the string length). One code unit
// is taken per clock cycle unless the queue is full. The back end takes a unit
// from the queue whenever one is there, except the last unit of a string while
// the previous result still waits. A four-entry queue sits between the
// classifier and the back end, so input keeps flowing while a result waits,
// until the queue fills. Result tvalid rises once the last unit of its string
// has passed the queue, the result stage and the output register.
// Configuration is written through a separate index/data channel that is
// always ready; write it only while idle.

module ucs2_string_to_integer_core import s2i_pkg::*; #(
  parameter int unsigned MAX_UNITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // last_unit
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [63:0] value, [65:64] status, [78:66] stop_pos
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  cfg_t              cfg_q;
  item_t             front_item, q_item;
  logic              q_valid, q_ready;
  logic              res_valid;
  logic [63:0]       res_value;
  status_e           res_status;
  logic [STOP_W-1:0] res_stop;

  // configuration registers, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix       <= RADIX_RESET;
      cfg_q.signed_mode <= 1'b1;
      cfg_q.wide_mode   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RADIX:  cfg_q.radix       <= cfg_data_i;
        REG_SIGNED: cfg_q.signed_mode <= cfg_data_i[0];
        REG_WIDE:   cfg_q.wide_mode   <= cfg_data_i[0];
        default:    cfg_q             <= cfg_q;
      endcase
    end
  end

  // classify the incoming unit
  s2i_front u_front (
    .code_unit_i (s_axis_tdata),
    .last_unit_i (s_axis_tlast),
    .item_o      (front_item)
  );

  // decouples the front from the back
  s2i_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_item_i  (front_item),
    .push_ready_o (s_axis_tready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_ready_i  (q_ready)
  );

  // parse state machine and result formatting
  s2i_back #(
    .MAX_UNITS (MAX_UNITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_ready_o (q_ready),
    .res_valid_o  (res_valid),
    .res_ready_i  (m_axis_tready),
    .res_value_o  (res_value),
    .res_status_o (res_status),
    .res_stop_o   (res_stop)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {1'b0, res_stop, res_status, res_value};

`ifndef ASSERT_OFF
  // a string without digits reports zero value and zero stop position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status == ST_NO_DIGITS) |-> (res_value == '0 && res_stop == '0))
    else $error("no-digits result with nonzero value or stop position");

  // a waiting result holds steady until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed or dropped while waiting");

  // stop position never passes the unit limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (MAX_UNITS > 8191 || int'(res_stop) <= MAX_UNITS))
    else $error("stop position beyond unit limit");

  // a result in narrow mode is never wider than 32 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !cfg_q.wide_mode) |-> (res_value[63:32] == '0))
    else $error("narrow mode result not zero-extended");
`endif

endmodule

// File: hw/rtl/s2i_front.sv
// front end: classifies each accepted code unit into skip, minus or other
// and its digit value; depends on s2i_pkg

module s2i_front import s2i_pkg::*; (
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output item_t       item_o
);

  logic [15:0] dig_raw;
  logic        dig_ok;

  always_comb begin
    dig_ok  = 1'b1;
    dig_raw = '0;
    if (code_unit_i >= CH_0 && code_unit_i <= CH_9) begin
      dig_raw = code_unit_i - CH_0;
    end else if (code_unit_i >= CH_UA && code_unit_i <= CH_UZ) begin
      dig_raw = code_unit_i - CH_UA + LETTER_BASE;
    end else if (code_unit_i >= CH_LA && code_unit_i <= CH_LZ) begin
      dig_raw = code_unit_i - CH_LA + LETTER_BASE;
    end else begin
      dig_ok = 1'b0;
    end
  end

  always_comb begin
    if (code_unit_i == CH_SPACE || code_unit_i == CH_TAB || code_unit_i == CH_PLUS) begin
      item_o.cls = CL_SKIP;
    end else if (code_unit_i == CH_MINUS) begin
      item_o.cls = CL_MINUS;
    end else begin
      item_o.cls = CL_OTHER;
    end
    item_o.dig_ok = dig_ok;
    item_o.dval   = dig_raw[5:0];
    item_o.last   = last_unit_i;
  end

endmodule

// File: hw/rtl/s2i_queue.sv
// small first-in first-out queue of classified items between front and back
// depends on s2i_pkg

module s2i_queue import s2i_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_ready_i
);

  item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: hw/rtl/s2i_back.sv
// back end: prefix/digit state machine with multiply-add accumulator,
// result stage and output register; depends on s2i_pkg

module s2i_back import s2i_pkg::*; #(
  parameter int unsigned MAX_UNITS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [63:0]       res_value_o,
  output status_e           res_status_o,
  output logic [STOP_W-1:0] res_stop_o
);

  localparam int unsigned IDX_W = $clog2(MAX_UNITS + 1);

  // parse state
  phase_e           phase_q, phase_d;
  logic             minus_q, minus_d;
  logic [63:0]      acc_q, acc_d;
  logic             ovf_q, ovf_d;
  logic             seen_q, seen_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // result stage and output register
  logic              fin_valid_q, fin_valid_d;
  fin_t              fin_q, fin_d;
  logic              out_valid_q;
  logic [63:0]       out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;
  logic [STOP_W-1:0] out_stop_q, out_stop_d;

  logic              fin_adv, fin_free, pop, fin_load;
  logic [5:0]        base;
  logic [63:0]       maxw;
  logic [69:0]       prod;
  phase_e            ph;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W+STOP_W-1:0] stop_ext;

  assign fin_adv      = fin_valid_q && (!out_valid_q || res_ready_i);
  assign fin_free     = !fin_valid_q || fin_adv;
  assign item_ready_o = !item_i.last || fin_free;
  assign pop          = item_valid_i && item_ready_o;

  assign base = (cfg_i.radix >= RADIX_MIN && cfg_i.radix <= RADIX_MAX) ?
                cfg_i.radix : RADIX_DEFAULT;
  assign maxw = cfg_i.wide_mode ? {64{1'b1}} : {32'b0, {32{1'b1}}};
  assign prod = 70'(acc_q) * 70'(base) + 70'(item_i.dval);

  always_comb begin
    phase_d  = phase_q;
    minus_d  = minus_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    seen_d   = seen_q;
    idx_d    = idx_q;
    ph       = phase_q;
    idx_next = idx_q;
    fin_load = 1'b0;
    stop_ext = '0;
    if (pop) begin
      if (ph == PH_PREFIX) begin
        unique case (item_i.cls)
          CL_SKIP:  ph = PH_PREFIX;
          CL_MINUS: minus_d = ~minus_q;
          default:  ph = PH_DIGITS;
        endcase
      end
      if (ph == PH_DIGITS) begin
        if (!item_i.dig_ok || item_i.dval >= base) begin
          ph = PH_STOPPED;
        end else begin
          // overflow when acc * base + digit leaves the width
          if (prod > 70'(maxw)) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = prod[63:0];
          end
          seen_d = 1'b1;
        end
      end
      if (ph != PH_STOPPED) begin
        idx_next = (idx_q == IDX_W'(MAX_UNITS)) ? idx_q : idx_q + 1'b1;
      end
      phase_d = ph;
      idx_d   = idx_next;
      if (item_i.last) begin
        fin_load = 1'b1;
        stop_ext = {{STOP_W{1'b0}}, idx_next};
        phase_d  = PH_PREFIX;
        minus_d  = 1'b0;
        acc_d    = '0;
        ovf_d    = 1'b0;
        seen_d   = 1'b0;
        idx_d    = '0;
      end
    end
  end

  always_comb begin
    fin_d             = fin_q;
    fin_d.acc         = acc_d;
    fin_d.minus       = minus_d;
    fin_d.ovf         = ovf_d;
    fin_d.seen        = seen_d;
    fin_d.signed_mode = cfg_i.signed_mode;
    fin_d.wide_mode   = cfg_i.wide_mode;
    fin_d.stop        = stop_ext[STOP_W-1:0];
    // take the values before the clear
    if (pop) begin
      fin_d.acc   = (ph == PH_DIGITS && item_i.dig_ok && item_i.dval < base &&
                     !(prod > 70'(maxw))) ? prod[63:0] : acc_q;
      fin_d.minus = (phase_q == PH_PREFIX && item_i.cls == CL_MINUS) ? ~minus_q : minus_q;
      fin_d.ovf   = ovf_q || (ph == PH_DIGITS && item_i.dig_ok && item_i.dval < base &&
                              prod > 70'(maxw));
      fin_d.seen  = seen_q || (ph == PH_DIGITS && item_i.dig_ok && item_i.dval < base);
    end
    if (fin_load) begin
      fin_valid_d = 1'b1;
    end else if (fin_adv) begin
      fin_valid_d = 1'b0;
    end else begin
      fin_valid_d = fin_valid_q;
    end
  end

  // result formatting: saturation, sign and width
  logic [63:0] top, fmaxw, neg;
  logic        f_ovf, ge_top, over_lim;

  always_comb begin
    top      = fin_q.wide_mode ? {1'b1, 63'b0} : {32'b0, 1'b1, 31'b0};
    fmaxw    = fin_q.wide_mode ? {64{1'b1}} : {32'b0, {32{1'b1}}};
    neg      = (64'd0 - fin_q.acc) & fmaxw;
    f_ovf    = fin_q.ovf || (!fin_q.wide_mode && (|fin_q.acc[63:32]));
    ge_top   = fin_q.wide_mode ? fin_q.acc[63] : (|fin_q.acc[63:31]);
    over_lim = fin_q.minus ? (ge_top && (fin_q.acc != top)) : ge_top;
    out_stop_d   = fin_q.stop;
    out_status_d = ST_OK;
    out_value_d  = fin_q.minus ? neg : fin_q.acc;
    if (!fin_q.seen) begin
      out_status_d = ST_NO_DIGITS;
      out_value_d  = '0;
      out_stop_d   = '0;
    end else if (fin_q.signed_mode) begin
      if (f_ovf || over_lim) begin
        out_status_d = ST_RANGE;
        out_value_d  = fin_q.minus ? top : top - 64'd1;
      end
    end else if (f_ovf) begin
      out_status_d = ST_RANGE;
      out_value_d  = fmaxw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PREFIX;
      minus_q     <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      seen_q      <= 1'b0;
      idx_q       <= '0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      minus_q     <= minus_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      seen_q      <= seen_d;
      idx_q       <= idx_d;
      fin_valid_q <= fin_valid_d;
      if (fin_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_q <= fin_d;
    end
    if (fin_adv) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_stop_q   <= out_stop_d;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_value_o  = out_value_q;
  assign res_status_o = out_status_q;
  assign res_stop_o   = out_stop_q;

endmodule
